[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared forms for concurrent checks
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on a given clock with an active-low reset
`define ASSERT_AT(lbl, ck, rst_n, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) else $error(msg);

// check on the block clock and reset
`define ASSERT_CLK(lbl, prop, msg) \
	`ASSERT_AT(lbl, clk, arst_n, prop, msg)

`endif

[rtl/acr_pkg.sv]
// ----------------------------------------------------------------------------
// acr_pkg
// types and constants of the box contact resolver
// ----------------------------------------------------------------------------
package acr_pkg;

	localparam int COMP_BITS  = 20;
	localparam int VEC_BITS   = 3 * COMP_BITS;
	localparam int CFG_BITS   = 10;
	localparam int MASK_BITS  = 16;
	localparam int WORLD_BITS = 8;
	localparam int ADDR_BITS  = 3;
	localparam int DATA_BITS  = 32;
	localparam int SD_BITS    = COMP_BITS + 3;
	localparam int P2_BITS    = COMP_BITS + 3;

	localparam logic REG_MARGIN = 1'b0;
	localparam logic REG_THRESH = 1'b1;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	localparam logic [CFG_BITS-1:0] MARGIN_RST = 10'd1;
	localparam logic [CFG_BITS-1:0] THRESH_RST = 10'd1;

	typedef logic [COMP_BITS-1:0] comp_t;
	typedef comp_t [2:0] vec_t;

	typedef struct packed {
		logic [VEC_BITS-1:0]   own_pos;
		logic [VEC_BITS-1:0]   own_vel;
		logic [VEC_BITS-1:0]   own_acc;
		logic [VEC_BITS-1:0]   own_size;
		logic [WORLD_BITS-1:0] own_world;
		logic [MASK_BITS-1:0]  own_mask;
		logic [VEC_BITS-1:0]   other_pos;
		logic [VEC_BITS-1:0]   other_vel;
		logic [VEC_BITS-1:0]   other_acc;
		logic [VEC_BITS-1:0]   other_extent;
		logic [WORLD_BITS-1:0] other_world;
		logic [MASK_BITS-1:0]  other_mask;
	} acr_in_t;

	typedef struct packed {
		logic [VEC_BITS-1:0] new_pos;
		logic [VEC_BITS-1:0] new_vel;
		logic [VEC_BITS-1:0] new_acc;
		logic                contact;
	} acr_out_t;

	typedef struct packed {
		vec_t                   own_pos;
		vec_t                   own_vel;
		vec_t                   own_acc;
		vec_t                   other_pos;
		vec_t                   other_vel;
		vec_t                   other_acc;
		logic [2:0][COMP_BITS:0] d;
		logic [2:0][COMP_BITS:0] sum;
		logic                   hit;
	} acr_s1_t;

	typedef struct packed {
		vec_t                   own_pos;
		vec_t                   own_vel;
		vec_t                   own_acc;
		vec_t                   other_pos;
		vec_t                   other_vel;
		vec_t                   other_acc;
		logic [2:0][COMP_BITS:0] sum;
		logic [2:0][SD_BITS-1:0] sdist;
		logic [2:0]             dneg;
		logic                   hit;
	} acr_s2_t;

	typedef struct packed {
		vec_t               own_pos;
		vec_t               own_vel;
		vec_t               own_acc;
		logic [1:0]         axis;
		logic               neg;
		logic [P2_BITS-1:0] p2;
		comp_t              pos_c;
		comp_t              vel_c;
		comp_t              ovel_c;
		comp_t              acc_c;
		comp_t              oacc_c;
		logic               hit;
	} acr_s3_t;

endpackage

[rtl/aabb_contact_resolver.sv]
// ----------------------------------------------------------------------------
// aabb_contact_resolver
// throughput: one box pair per cycle while the response is not stalled, through four pipeline stages
// stalls back up stage by stage, so bubbles still fill while a response waits
// reset clears all stage valid bits and loads margin and threshold with one
// ----------------------------------------------------------------------------
module aabb_contact_resolver import acr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  acr_in_t              req_data,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output acr_out_t             rsp_data,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	output logic [DATA_BITS-1:0] prdata,
	output logic                 pready
);

	logic [CFG_BITS-1:0] margin_q;
	logic [CFG_BITS-1:0] thresh_q;
	logic                s2_valid;
	acr_s2_t             s2_data;
	logic                s2_ready;
	logic                wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= MARGIN_RST;
			thresh_q <= THRESH_RST;
		end else if (wr_en) begin
			case (paddr[2])
				REG_MARGIN: margin_q <= pwdata[CFG_BITS-1:0];
				REG_THRESH: thresh_q <= pwdata[CFG_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_MARGIN: prdata = {{(DATA_BITS-CFG_BITS){1'b0}}, margin_q};
			REG_THRESH: prdata = {{(DATA_BITS-CFG_BITS){1'b0}}, thresh_q};
			default:    prdata = '0;
		endcase
	end

	acr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.margin     (margin_q),
		.req_valid  (req_valid),
		.req_data   (req_data),
		.req_stall  (req_stall),
		.down_ready (s2_ready),
		.s2_valid   (s2_valid),
		.s2_data    (s2_data)
	);

	acr_resolve u_resolve (
		.clk       (clk),
		.arst_n    (arst_n),
		.margin    (margin_q),
		.thresh    (thresh_q),
		.up_valid  (s2_valid),
		.up_data   (s2_data),
		.up_ready  (s2_ready),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

endmodule

[rtl/acr_front.sv]
// ----------------------------------------------------------------------------
// acr_front
// stages one and two: offsets, extents, separation test, surface distances
// ----------------------------------------------------------------------------
module acr_front import acr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [CFG_BITS-1:0] margin,
	input  logic                req_valid,
	input  acr_in_t             req_data,
	output logic                req_stall,
	input  logic                down_ready,
	output logic                s2_valid,
	output acr_s2_t             s2_data
);

	logic    valid_s1;
	acr_s1_t data_s1;
	acr_s1_t s1_n;
	logic    valid_s2;
	acr_s2_t data_s2;
	acr_s2_t s2_n;
	logic    ready_s1;
	logic    ready_s2;

	assign ready_s2  = !valid_s2 || down_ready;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign req_stall = !ready_s1;
	assign s2_valid  = valid_s2;
	assign s2_data   = data_s2;

	always_comb begin
		comp_t e1;
		comp_t e2;
		comp_t pa;
		comp_t pb;
		s1_n           = '0;
		s1_n.own_pos   = vec_t'(req_data.own_pos);
		s1_n.own_vel   = vec_t'(req_data.own_vel);
		s1_n.own_acc   = vec_t'(req_data.own_acc);
		s1_n.other_pos = vec_t'(req_data.other_pos);
		s1_n.other_vel = vec_t'(req_data.other_vel);
		s1_n.other_acc = vec_t'(req_data.other_acc);
		for (int a = 0; a < 3; a++) begin
			e1 = req_data.own_size[a*COMP_BITS +: COMP_BITS];
			e2 = req_data.other_extent[a*COMP_BITS +: COMP_BITS];
			// negative extent counts as empty
			if (e1[COMP_BITS-1]) begin
				e1 = '0;
			end
			if (e2[COMP_BITS-1]) begin
				e2 = '0;
			end
			s1_n.sum[a] = {1'b0, e1} + {1'b0, e2};
			pa = req_data.own_pos[a*COMP_BITS +: COMP_BITS];
			pb = req_data.other_pos[a*COMP_BITS +: COMP_BITS];
			s1_n.d[a] = {pa[COMP_BITS-1], pa} - {pb[COMP_BITS-1], pb};
		end
		s1_n.hit = (|(req_data.own_mask & req_data.other_mask)) &&
			(req_data.own_world == req_data.other_world);
	end

	always_comb begin
		logic [COMP_BITS:0]   ad;
		logic [COMP_BITS+1:0] two_ad;
		logic [COMP_BITS+1:0] lim;
		logic                 apart;
		apart          = 1'b0;
		s2_n           = '0;
		s2_n.own_pos   = data_s1.own_pos;
		s2_n.own_vel   = data_s1.own_vel;
		s2_n.own_acc   = data_s1.own_acc;
		s2_n.other_pos = data_s1.other_pos;
		s2_n.other_vel = data_s1.other_vel;
		s2_n.other_acc = data_s1.other_acc;
		s2_n.sum       = data_s1.sum;
		for (int a = 0; a < 3; a++) begin
			ad = data_s1.d[a][COMP_BITS] ? (~data_s1.d[a] + 1'b1) : data_s1.d[a];
			two_ad = {ad, 1'b0};
			lim = {1'b0, data_s1.sum[a]} +
				{{(COMP_BITS+1-CFG_BITS){1'b0}}, margin, 1'b0};
			if (two_ad >= lim) begin
				apart = 1'b1;
			end
			s2_n.sdist[a] = {1'b0, two_ad} - {2'b00, data_s1.sum[a]};
			s2_n.dneg[a]  = data_s1.d[a][COMP_BITS];
		end
		s2_n.hit = data_s1.hit && !apart;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= req_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && req_valid) begin
			data_s1 <= s1_n;
		end
		if (ready_s2 && valid_s1) begin
			data_s2 <= s2_n;
		end
	end

endmodule

[rtl/acr_resolve.sv]
// ----------------------------------------------------------------------------
// acr_resolve
// stages three and four: axis choice, push-out target, motion removal
// ----------------------------------------------------------------------------
module acr_resolve import acr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [CFG_BITS-1:0] margin,
	input  logic [CFG_BITS-1:0] thresh,
	input  logic                up_valid,
	input  acr_s2_t             up_data,
	output logic                up_ready,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output acr_out_t            rsp_data
);

	logic     valid_s3;
	acr_s3_t  data_s3;
	acr_s3_t  s3_n;
	logic     valid_s4;
	acr_out_t data_s4;
	acr_out_t s4_n;
	logic     ready_s3;
	logic     ready_s4;

	assign ready_s4  = !valid_s4 || !rsp_stall;
	assign ready_s3  = !valid_s3 || ready_s4;
	assign up_ready  = ready_s3;
	assign rsp_valid = valid_s4;
	assign rsp_data  = data_s4;

	always_comb begin
		logic [1:0]           axis;
		comp_t                opos_c;
		logic [COMP_BITS:0]   sm;
		logic [COMP_BITS+1:0] push;
		logic [P2_BITS-1:0]   pe;
		logic [P2_BITS-1:0]   base;
		logic                 neg;
		s3_n = '0;
		// least penetration, ties go to z before y before x
		if ($signed(up_data.sdist[0]) > $signed(up_data.sdist[1]) &&
			$signed(up_data.sdist[0]) > $signed(up_data.sdist[2])) begin
			axis = AXIS_X;
		end else if ($signed(up_data.sdist[1]) > $signed(up_data.sdist[2])) begin
			axis = AXIS_Y;
		end else begin
			axis = AXIS_Z;
		end
		case (axis)
			AXIS_X: begin
				opos_c      = up_data.other_pos[0];
				sm          = up_data.sum[0];
				neg         = up_data.dneg[0];
				s3_n.pos_c  = up_data.own_pos[0];
				s3_n.vel_c  = up_data.own_vel[0];
				s3_n.ovel_c = up_data.other_vel[0];
				s3_n.acc_c  = up_data.own_acc[0];
				s3_n.oacc_c = up_data.other_acc[0];
			end
			AXIS_Y: begin
				opos_c      = up_data.other_pos[1];
				sm          = up_data.sum[1];
				neg         = up_data.dneg[1];
				s3_n.pos_c  = up_data.own_pos[1];
				s3_n.vel_c  = up_data.own_vel[1];
				s3_n.ovel_c = up_data.other_vel[1];
				s3_n.acc_c  = up_data.own_acc[1];
				s3_n.oacc_c = up_data.other_acc[1];
			end
			default: begin
				opos_c      = up_data.other_pos[2];
				sm          = up_data.sum[2];
				neg         = up_data.dneg[2];
				s3_n.pos_c  = up_data.own_pos[2];
				s3_n.vel_c  = up_data.own_vel[2];
				s3_n.ovel_c = up_data.other_vel[2];
				s3_n.acc_c  = up_data.own_acc[2];
				s3_n.oacc_c = up_data.other_acc[2];
			end
		endcase
		// target in half units: 2*other + sign*(extent sum + margin)
		push = {1'b0, sm} + {{(COMP_BITS+2-CFG_BITS){1'b0}}, margin};
		pe   = {1'b0, push};
		base = {{2{opos_c[COMP_BITS-1]}}, opos_c, 1'b0};
		s3_n.p2      = base + (neg ? (~pe + 1'b1) : pe);
		s3_n.axis    = axis;
		s3_n.neg     = neg;
		s3_n.own_pos = up_data.own_pos;
		s3_n.own_vel = up_data.own_vel;
		s3_n.own_acc = up_data.own_acc;
		s3_n.hit     = up_data.hit;
	end

	always_comb begin
		logic [P2_BITS:0]     t;
		logic [P2_BITS:0]     n;
		logic [COMP_BITS+1:0] q;
		comp_t                qc;
		logic [P2_BITS-1:0]   pos2;
		logic [COMP_BITS:0]   dv;
		logic [COMP_BITS:0]   da;
		logic [COMP_BITS+1:0] vdot;
		logic [COMP_BITS+1:0] adot;
		logic [COMP_BITS+1:0] eps;
		logic                 vslow;
		logic                 aslow;
		vec_t                 pos_n;
		vec_t                 vel_n;
		vec_t                 acc_n;
		pos2 = {{2{data_s3.pos_c[COMP_BITS-1]}}, data_s3.pos_c, 1'b0};
		t    = {data_s3.p2[P2_BITS-1], data_s3.p2} + {pos2[P2_BITS-1], pos2};
		// quarter with ties upward, then saturate
		n = t + 2'd2;
		q = n[P2_BITS:2];
		if (q[COMP_BITS+1:COMP_BITS-1] == 3'b000 || q[COMP_BITS+1:COMP_BITS-1] == 3'b111) begin
			qc = q[COMP_BITS-1:0];
		end else if (q[COMP_BITS+1]) begin
			qc = {1'b1, {(COMP_BITS-1){1'b0}}};
		end else begin
			qc = {1'b0, {(COMP_BITS-1){1'b1}}};
		end
		dv = {data_s3.vel_c[COMP_BITS-1], data_s3.vel_c} -
			{data_s3.ovel_c[COMP_BITS-1], data_s3.ovel_c};
		da = {data_s3.acc_c[COMP_BITS-1], data_s3.acc_c} -
			{data_s3.oacc_c[COMP_BITS-1], data_s3.oacc_c};
		vdot = data_s3.neg ? (~{dv[COMP_BITS], dv} + 1'b1) : {dv[COMP_BITS], dv};
		adot = data_s3.neg ? (~{da[COMP_BITS], da} + 1'b1) : {da[COMP_BITS], da};
		eps  = {{(COMP_BITS+2-CFG_BITS){1'b0}}, thresh};
		vslow = $signed(vdot) < $signed(eps);
		aslow = vslow && ($signed(adot) < $signed(eps));
		pos_n = data_s3.own_pos;
		vel_n = data_s3.own_vel;
		acc_n = data_s3.own_acc;
		if (data_s3.hit) begin
			case (data_s3.axis)
				AXIS_X: begin
					pos_n[0] = qc;
					if (vslow) begin
						vel_n[0] = data_s3.ovel_c;
					end
					if (aslow) begin
						acc_n[0] = data_s3.oacc_c;
					end
				end
				AXIS_Y: begin
					pos_n[1] = qc;
					if (vslow) begin
						vel_n[1] = data_s3.ovel_c;
					end
					if (aslow) begin
						acc_n[1] = data_s3.oacc_c;
					end
				end
				default: begin
					pos_n[2] = qc;
					if (vslow) begin
						vel_n[2] = data_s3.ovel_c;
					end
					if (aslow) begin
						acc_n[2] = data_s3.oacc_c;
					end
				end
			endcase
		end
		s4_n.new_pos = pos_n;
		s4_n.new_vel = vel_n;
		s4_n.new_acc = acc_n;
		s4_n.contact = data_s3.hit && (vslow || (data_s3.p2 != pos2));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s3) begin
				valid_s3 <= up_valid;
			end
			if (ready_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && up_valid) begin
			data_s3 <= s3_n;
		end
		if (ready_s4 && valid_s3) begin
			data_s4 <= s4_n;
		end
	end

endmodule

[rtl/acr_checker.sv]
// ----------------------------------------------------------------------------
// acr_checker
// port-level checks of the box contact resolver
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module acr_checker import acr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	input  logic                 req_stall,
	input  logic                 rsp_valid,
	input  logic                 rsp_stall,
	input  acr_out_t             rsp_data,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	input  logic [DATA_BITS-1:0] prdata,
	input  logic                 pready
);

	// response held while stalled
	`ASSERT_CLK(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "response changed under stall")

	// empty output stage means the pipe can take a request
	`ASSERT_CLK(a_no_stall_empty, !rsp_valid |-> !req_stall, "request stalled with empty output")

	// registers read back with zero upper bits
	`ASSERT_CLK(a_rd_width, pready |-> prdata[DATA_BITS-1:CFG_BITS] == '0, "read data above register width")

	// margin write is seen on the next read
	`ASSERT_CLK(a_wr_rd, (arst_n && psel && penable && pwrite && pready && !paddr[2]) ##1 (!paddr[2]) |-> prdata[CFG_BITS-1:0] == $past(pwdata[CFG_BITS-1:0]), "margin readback mismatch")

endmodule

bind aabb_contact_resolver acr_checker u_acr_checker (.*);

[verif/tb_aabb_contact_resolver.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aabb_contact_resolver
// Streams box pairs through the contact resolver and compares every response
// against a local prediction of the push-out, axis choice and motion removal.
// Directed pairs cover the no-contact cases, axis priority, threshold edges,
// saturation and negative extents. Random pairs follow under several margin
// and threshold settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_aabb_contact_resolver import acr_pkg::*; ();

	localparam int COMP_HI = 2**(COMP_BITS-1) - 1;
	localparam int COMP_LO = -COMP_HI - 1;
	localparam int CYCLE_LIMIT = 200000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	acr_in_t              req_data = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	acr_out_t             rsp_data;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [ADDR_BITS-1:0] paddr = '0;
	logic [DATA_BITS-1:0] pwdata = '0;
	logic [DATA_BITS-1:0] prdata;
	logic                 pready;

	logic [CFG_BITS-1:0] margin_cfg = MARGIN_RST;
	logic [CFG_BITS-1:0] thresh_cfg = THRESH_RST;
	acr_out_t            resolved_boxes[$];
	int                  mismatches = 0;
	int                  cycle_count = 0;
	int                  stall_left = 0;
	bit                  idle_on = 1'b1;

	aabb_contact_resolver DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_aabb_contact_resolver failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (stall_left > 0) begin
			rsp_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			rsp_stall <= 1'b1;
			stall_left <= $urandom_range(0, 4);
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	function automatic longint comp_val(logic [VEC_BITS-1:0] v, int axis);
		comp_t c;
		c = v[axis*COMP_BITS +: COMP_BITS];
		return longint'($signed(c));
	endfunction

	function automatic vec_t vec3(int x, int y, int z);
		vec_t v;
		v[0] = x[COMP_BITS-1:0];
		v[1] = y[COMP_BITS-1:0];
		v[2] = z[COMP_BITS-1:0];
		return v;
	endfunction

	function automatic acr_out_t resolve_contact(acr_in_t r, logic [CFG_BITS-1:0] margin,
			logic [CFG_BITS-1:0] thresh);
		acr_out_t o;
		longint   m, eps, e1, e2, ad, sgn, p2, twice_pos, q, vdot, adot;
		longint   dv[3], sm[3], sd[3];
		bit       apart;
		int       ax;
		o.new_pos = r.own_pos;
		o.new_vel = r.own_vel;
		o.new_acc = r.own_acc;
		o.contact = 1'b0;
		m = longint'(margin);
		eps = longint'(thresh);
		apart = ((r.own_mask & r.other_mask) == '0) || (r.own_world != r.other_world);
		for (int a = 0; a < 3; a++) begin
			e1 = comp_val(r.own_size, a);
			e2 = comp_val(r.other_extent, a);
			if (e1 < 0)
				e1 = 0;
			if (e2 < 0)
				e2 = 0;
			sm[a] = e1 + e2;
			dv[a] = comp_val(r.own_pos, a) - comp_val(r.other_pos, a);
			ad = (dv[a] < 0) ? -dv[a] : dv[a];
			if (2 * ad - 2 * m >= sm[a])
				apart = 1'b1;
			sd[a] = 2 * ad - sm[a];
		end
		if (!apart) begin
			if (sd[0] > sd[1] && sd[0] > sd[2])
				ax = int'(AXIS_X);
			else if (sd[1] > sd[2])
				ax = int'(AXIS_Y);
			else
				ax = int'(AXIS_Z);
			sgn = (dv[ax] < 0) ? -1 : 1;
			twice_pos = 2 * comp_val(r.own_pos, ax);
			p2 = 2 * comp_val(r.other_pos, ax) + sgn * (sm[ax] + m);
			o.contact = (p2 != twice_pos);
			// nearest quarter, ties upward
			q = (p2 + twice_pos + 2) >>> 2;
			if (q > COMP_HI)
				q = COMP_HI;
			if (q < COMP_LO)
				q = COMP_LO;
			o.new_pos[ax*COMP_BITS +: COMP_BITS] = q[COMP_BITS-1:0];
			vdot = sgn * (comp_val(r.own_vel, ax) - comp_val(r.other_vel, ax));
			if (vdot < eps) begin
				o.new_vel[ax*COMP_BITS +: COMP_BITS] = r.other_vel[ax*COMP_BITS +: COMP_BITS];
				o.contact = 1'b1;
				adot = sgn * (comp_val(r.own_acc, ax) - comp_val(r.other_acc, ax));
				if (adot < eps)
					o.new_acc[ax*COMP_BITS +: COMP_BITS] =
						r.other_acc[ax*COMP_BITS +: COMP_BITS];
			end
		end
		return o;
	endfunction

	function automatic acr_in_t box_pair(vec_t own_at, vec_t other_at);
		acr_in_t p;
		p = '0;
		p.own_pos = own_at;
		p.other_pos = other_at;
		p.own_size = vec3(10, 10, 10);
		p.other_extent = vec3(10, 10, 10);
		p.own_world = 8'd3;
		p.other_world = 8'd3;
		p.own_mask = 16'h0001;
		p.other_mask = 16'h0003;
		return p;
	endfunction

	function automatic acr_in_t near(int dx, int dy, int dz);
		return box_pair(vec3(100 + dx, -200 + dy, 300 + dz), vec3(100, -200, 300));
	endfunction

	function automatic acr_in_t rand_pair();
		acr_in_t      p;
		logic [543:0] raw;
		int           e_own, e_other, reach, k, bitpos;
		for (int i = 0; i < 544; i += 32)
			raw[i +: 32] = $urandom;
		p = raw[$bits(acr_in_t)-1:0];
		if ($urandom_range(0, 4) == 0)
			return p;
		if ($urandom_range(0, 19) != 0)
			p.other_world = p.own_world;
		if ($urandom_range(0, 19) != 0) begin
			bitpos = $urandom_range(0, MASK_BITS - 1);
			p.own_mask[bitpos] = 1'b1;
			p.other_mask[bitpos] = 1'b1;
		end
		for (int a = 0; a < 3; a++) begin
			if ($urandom_range(0, 7) != 0) begin
				p.own_size[a*COMP_BITS +: COMP_BITS] = COMP_BITS'($urandom_range(0, 600));
				p.other_extent[a*COMP_BITS +: COMP_BITS] = COMP_BITS'($urandom_range(0, 600));
			end
			e_own = int'(comp_val(p.own_size, a));
			e_other = int'(comp_val(p.other_extent, a));
			if (e_own < 0)
				e_own = 0;
			if (e_other < 0)
				e_other = 0;
			reach = (e_own + e_other) / 2 + int'(margin_cfg) + 3;
			k = $urandom_range(0, 2 * reach);
			p.own_pos[a*COMP_BITS +: COMP_BITS] =
				COMP_BITS'(comp_val(p.other_pos, a) + (k - reach));
			reach = int'(thresh_cfg) + 16;
			if ($urandom_range(0, 3) != 0) begin
				k = $urandom_range(0, 2 * reach);
				p.own_vel[a*COMP_BITS +: COMP_BITS] =
					COMP_BITS'(comp_val(p.other_vel, a) + (k - reach));
			end
			if ($urandom_range(0, 3) != 0) begin
				k = $urandom_range(0, 2 * reach);
				p.own_acc[a*COMP_BITS +: COMP_BITS] =
					COMP_BITS'(comp_val(p.other_acc, a) + (k - reach));
			end
		end
		return p;
	endfunction

	always @(negedge clk) begin : check_response
		acr_out_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (resolved_boxes.size() == 0) begin
				$error("response with no request outstanding");
				mismatches++;
			end else begin
				want = resolved_boxes.pop_front();
				if (rsp_data.new_pos !== want.new_pos) begin
					$error("new_pos expected %h actual %h", want.new_pos, rsp_data.new_pos);
					mismatches++;
				end
				if (rsp_data.new_vel !== want.new_vel) begin
					$error("new_vel expected %h actual %h", want.new_vel, rsp_data.new_vel);
					mismatches++;
				end
				if (rsp_data.new_acc !== want.new_acc) begin
					$error("new_acc expected %h actual %h", want.new_acc, rsp_data.new_acc);
					mismatches++;
				end
				if (rsp_data.contact !== want.contact) begin
					$error("contact expected %b actual %b", want.contact, rsp_data.contact);
					mismatches++;
				end
			end
		end
	end

	task automatic send_pair(acr_in_t pair);
		bit taken;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= pair;
		do begin
			@(negedge clk);
			taken = !req_stall;
			@(posedge clk);
		end while (!taken);
		resolved_boxes.push_back(resolve_contact(pair, margin_cfg, thresh_cfg));
	endtask

	task automatic wait_idle();
		req_valid <= 1'b0;
		while (resolved_boxes.size() != 0)
			@(posedge clk);
	endtask

	task automatic reg_write(logic [ADDR_BITS-1:0] addr, logic [DATA_BITS-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_BITS'(REG_MARGIN) << 2)
			margin_cfg = value[CFG_BITS-1:0];
		else if (addr == ADDR_BITS'(REG_THRESH) << 2)
			thresh_cfg = value[CFG_BITS-1:0];
		@(posedge clk);
	endtask

	task automatic set_limits(logic [CFG_BITS-1:0] margin, logic [CFG_BITS-1:0] thresh);
		wait_idle();
		reg_write(ADDR_BITS'(REG_MARGIN) << 2, {22'($urandom), margin});
		reg_write(ADDR_BITS'(REG_THRESH) << 2, {22'($urandom), thresh});
	endtask

	task automatic run_random(int count);
		repeat (count) begin
			if (idle_on && $urandom_range(0, 59) == 0)
				wait_idle();
			send_pair(rand_pair());
		end
	endtask

	task automatic test_no_contact();
		acr_in_t p;
		p = near(2, 5, 8);
		p.own_mask = 16'h00F0;
		p.other_mask = 16'h0F00;
		send_pair(p);
		p = near(2, 5, 8);
		p.other_world = 8'd4;
		send_pair(p);
		send_pair(near(11, 0, 0));
		send_pair(near(0, 11, 0));
		send_pair(near(0, 0, -11));
		wait_idle();
	endtask

	task automatic test_axis_choice();
		send_pair(near(8, 2, 5));
		send_pair(near(2, 8, 5));
		send_pair(near(2, 5, 8));
		send_pair(near(-8, 2, 5));
		send_pair(near(0, -8, 3));
		send_pair(near(5, 5, 5));
		send_pair(near(8, 8, 2));
		send_pair(near(10, -10, 10));
		wait_idle();
	endtask

	task automatic test_motion_removal();
		acr_in_t p;
		// already at the surface and moving away
		p = near(10, 0, 0);
		p.other_extent = vec3(9, 10, 10);
		p.own_vel = vec3(3, 0, 0);
		send_pair(p);
		p = near(8, 2, 5);
		p.own_vel = vec3(5, -7, 9);
		send_pair(p);
		p = near(8, 2, 5);
		p.own_vel = vec3(1, 0, 0);
		send_pair(p);
		p = near(8, 2, 5);
		p.own_vel = vec3(-4, 3, 3);
		p.own_acc = vec3(6, 1, 1);
		p.other_vel = vec3(0, 2, 2);
		p.other_acc = vec3(0, 0, 9);
		send_pair(p);
		p.own_acc = vec3(-6, 1, 1);
		send_pair(p);
		p = near(-8, 2, 5);
		p.own_vel = vec3(COMP_HI, 0, 0);
		p.other_vel = vec3(COMP_LO, 0, 0);
		p.own_acc = vec3(COMP_LO, 0, 0);
		p.other_acc = vec3(COMP_HI, 0, 0);
		send_pair(p);
		wait_idle();
	endtask

	task automatic test_extremes();
		acr_in_t p;
		send_pair('1);
		send_pair('0);
		p = box_pair(vec3(0, 0, COMP_HI), vec3(0, 0, COMP_HI));
		p.own_size = vec3(1000, 1000, 1000);
		p.other_extent = vec3(1000, 1000, 1000);
		send_pair(p);
		p = box_pair(vec3(0, 0, COMP_LO), vec3(0, 0, COMP_LO + 1));
		p.own_size = vec3(1000, 1000, 1000);
		p.other_extent = vec3(1000, 1000, 1000);
		send_pair(p);
		p = box_pair(vec3(COMP_HI, COMP_LO, COMP_HI), vec3(COMP_HI - 3, COMP_LO + 2, COMP_HI));
		p.own_size = vec3(COMP_HI, COMP_HI, COMP_HI);
		p.other_extent = vec3(COMP_HI, COMP_HI, COMP_HI);
		send_pair(p);
		// negative extents count as empty
		p = near(2, 5, 8);
		p.own_size = vec3(-5, -1, 10);
		p.other_extent = vec3(4, COMP_LO, 10);
		send_pair(p);
		p = near(3, 1, 2);
		p.own_mask = 16'hFFFF;
		p.other_mask = 16'hFFFF;
		p.own_world = 8'hFF;
		p.other_world = 8'hFF;
		send_pair(p);
		wait_idle();
	endtask

	task automatic test_config_sweep();
		set_limits('0, '0);
		send_pair(near(10, 0, 0));
		send_pair(near(8, 2, 5));
		run_random(80);
		set_limits('1, '1);
		send_pair(near(520, 0, 0));
		send_pair(near(-530, 3, 1));
		run_random(80);
		repeat (3) begin
			set_limits(CFG_BITS'($urandom), CFG_BITS'($urandom));
			run_random(50);
		end
	endtask

	task automatic test_streaming();
		idle_on = 1'b0;
		set_limits(CFG_BITS'($urandom_range(0, 64)), CFG_BITS'($urandom_range(0, 64)));
		run_random(60);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_no_contact();
		test_axis_choice();
		test_motion_removal();
		test_extremes();
		test_config_sweep();
		test_streaming();
		wait_idle();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("tb_aabb_contact_resolver passed");
		else
			$display("tb_aabb_contact_resolver failed");
		$finish;
	end

endmodule
